@@ rtl/core/rph_pkg.sv @@
// Shared constants, codes and types for the read position histogram.
package rph_pkg;

   // Store geometry
   localparam int NUM_CHROMS     = 32;
   localparam int BINS_PER_CHROM = 16384;
   localparam int DUMP_GROUP     = 16;
   localparam int CHROM_W        = $clog2(NUM_CHROMS);
   localparam int BIN_W          = $clog2(BINS_PER_CHROM);
   localparam int ADDR_W         = CHROM_W + BIN_W;
   localparam int STORE_DEPTH    = 2 ** ADDR_W;

   // Field widths
   localparam int REQ_TYPE_W  = 1;
   localparam int CHROM_IDX_W = 5;
   localparam int COORD_W     = 32;
   localparam int STRAND_W    = 2;
   localparam int GROUP_W     = 10;
   localparam int STATUS_W    = 3;
   localparam int START_W     = 33;
   localparam int VALUE_W     = 32;
   localparam int SUM_W       = VALUE_W + 1;

   // Configuration widths
   localparam int BS_W       = 21;
   localparam int SHIFT_W    = 31;
   localparam int WEIGHT_W   = 16;
   localparam int SKIP_W     = 6;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 31;

   // Datapath widths
   localparam int POS_W      = COORD_W + 1;
   localparam int REM_W      = BS_W;
   localparam int DIV_CNT_W  = $clog2(POS_W + 1);
   localparam int PROD_W     = BIN_W + BS_W;
   localparam int SCAN_W     = GROUP_W + 6;
   localparam int SCAN_CNT_W = $clog2(DUMP_GROUP + 1);

   // Queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Status codes
   localparam logic [STATUS_W-1:0] ST_COUNTED    = 3'd0;
   localparam logic [STATUS_W-1:0] ST_TOO_CLOSE  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_SKIPPED    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_BAD_STRAND = 3'd3;
   localparam logic [STATUS_W-1:0] ST_RANGE      = 3'd4;
   localparam logic [STATUS_W-1:0] ST_DUMP       = 3'd5;

   // Request kinds and strands
   localparam logic [REQ_TYPE_W-1:0] REQ_READ = 1'b0;
   localparam logic [REQ_TYPE_W-1:0] REQ_DUMP = 1'b1;
   localparam logic [STRAND_W-1:0] STRAND_PLUS  = 2'd0;
   localparam logic [STRAND_W-1:0] STRAND_MINUS = 2'd1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BIN_WIDTH     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SHIFT_AMOUNT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_READ_WEIGHT   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SKIPPED_CHROM = 2'd3;

   typedef struct packed {
      logic [BS_W-1:0]     bin_width;
      logic [SHIFT_W-1:0]  shift_amount;
      logic [WEIGHT_W-1:0] read_weight;
      logic [SKIP_W-1:0]   skipped_chrom;
   } cfg_type;

   // Classified work item; for a read, ST_COUNTED means go on to binning
   typedef struct packed {
      logic                is_dump;
      logic [STATUS_W-1:0] status;
      logic [CHROM_W-1:0]  chrom;
      logic                chrom_ok;
      logic [POS_W-1:0]    pos;
      logic [GROUP_W-1:0]  group;
   } work_type;

endpackage

@@ rtl/core/rph_req_if.sv @@
// Request channel: valid/ready handshake with the record or dump payload.
interface rph_req_if;
   import rph_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [REQ_TYPE_W-1:0]  req_type;
   logic [CHROM_IDX_W-1:0] chrom_index;
   logic [COORD_W-1:0]     read_start;
   logic [COORD_W-1:0]     read_end;
   logic [STRAND_W-1:0]    strand;
   logic [GROUP_W-1:0]     bin_group;

   modport source (output valid, req_type, chrom_index, read_start, read_end, strand,
                   bin_group, input ready);
   modport sink (input valid, req_type, chrom_index, read_start, read_end, strand,
                 bin_group, output ready);
endinterface

@@ rtl/core/rph_rsp_if.sv @@
// Result channel: valid/ready handshake with the result payload.
interface rph_rsp_if;
   import rph_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [START_W-1:0]  bin_start;
   logic [VALUE_W-1:0]  bin_value;
   logic                last;

   modport source (output valid, status, bin_start, bin_value, last, input ready);
   modport sink (input valid, status, bin_start, bin_value, last, output ready);
endinterface

@@ rtl/core/rph_front.sv @@
// Front end: takes request transfers, works out position and early status.
module rph_front (
   input  rph_pkg::cfg_type  cfg,
   input  logic              clearing,
   input  logic              q_full,
   output logic              q_push,
   output rph_pkg::work_type q_item,
   rph_req_if.sink           req
);
   import rph_pkg::*;

   logic chrom_ok;

   assign req.ready = !clearing && !q_full;
   assign q_push    = req.valid && req.ready;
   assign chrom_ok  = 32'(req.chrom_index) < NUM_CHROMS;

   always_comb begin
      q_item          = '0;
      q_item.is_dump  = (req.req_type == REQ_DUMP);
      q_item.chrom    = req.chrom_index[CHROM_W-1:0];
      q_item.chrom_ok = chrom_ok;
      q_item.group    = req.bin_group;
      q_item.status   = ST_COUNTED;
      // check order: skipped chromosome, range, strand, minus distance
      if ({1'b0, req.chrom_index} == cfg.skipped_chrom) begin
         q_item.status = ST_SKIPPED;
      end else if (!chrom_ok) begin
         q_item.status = ST_RANGE;
      end else if (req.strand == STRAND_PLUS) begin
         q_item.pos = POS_W'(req.read_start) + POS_W'(cfg.shift_amount);
      end else if (req.strand == STRAND_MINUS) begin
         if (req.read_end > COORD_W'(cfg.shift_amount)) begin
            q_item.pos = POS_W'(req.read_end - COORD_W'(cfg.shift_amount));
         end else begin
            q_item.status = ST_TOO_CLOSE;
         end
      end else begin
         q_item.status = ST_BAD_STRAND;
      end
   end

endmodule

@@ rtl/core/rph_queue.sv @@
// Short queue of classified items between front and back.
module rph_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  rph_pkg::work_type push_item,
   input  logic              pop,
   output logic              full,
   output logic              valid,
   output rph_pkg::work_type head_item
);
   import rph_pkg::*;

   work_type            entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign valid     = (count_ff != '0);
   assign head_item = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> valid)
      else $error("queue pop while empty");

endmodule

@@ rtl/core/rph_back.sv @@
// Back end: bin divider, bin store update, dump scan and result register.
module rph_back (
   input  logic              clock,
   input  logic              reset,
   input  rph_pkg::cfg_type  cfg,
   input  logic              q_valid,
   input  rph_pkg::work_type q_item,
   output logic              q_pop,
   output logic              clearing,
   rph_rsp_if.source         rsp
);
   import rph_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_DIV   = 3'd1;
   localparam logic [2:0] S_CHECK = 3'd2;
   localparam logic [2:0] S_RWAIT = 3'd3;
   localparam logic [2:0] S_DRD   = 3'd4;
   localparam logic [2:0] S_DWAIT = 3'd5;
   localparam logic [2:0] S_EMIT  = 3'd6;

   logic [2:0]            state_ff, state_in;
   logic                  clearing_ff, clearing_in;
   logic [ADDR_W-1:0]     clr_addr_ff, clr_addr_in;
   logic [CHROM_W-1:0]    chrom_ff, chrom_in;
   logic [REM_W-1:0]      div_rem_ff, div_rem_in;
   logic [POS_W-1:0]      div_quo_ff, div_quo_in;
   logic [DIV_CNT_W-1:0]  div_cnt_ff, div_cnt_in;
   logic [SCAN_W-1:0]     scan_bin_ff, scan_bin_in;
   logic [SCAN_CNT_W-1:0] scan_cnt_ff, scan_cnt_in;
   logic [PROD_W-1:0]     prod_ff, prod_in;
   logic [STATUS_W-1:0]   pend_status_ff, pend_status_in;
   logic [START_W-1:0]    pend_start_ff, pend_start_in;
   logic [VALUE_W-1:0]    pend_value_ff, pend_value_in;
   logic                  pend_last_ff, pend_last_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]   rsp_status_ff;
   logic [START_W-1:0]    rsp_start_ff;
   logic [VALUE_W-1:0]    rsp_value_ff;
   logic                  rsp_last_ff;

   logic [VALUE_W-1:0]    store [STORE_DEPTH];
   logic [VALUE_W-1:0]    mem_q_ff;
   logic [ADDR_W-1:0]     rd_addr;
   logic [ADDR_W-1:0]     wr_addr;
   logic [VALUE_W-1:0]    wr_data;
   logic                  mem_we;

   logic [REM_W:0]        div_trial;
   logic                  div_ge;
   logic [BIN_W-1:0]      mul_a;
   logic [SUM_W-1:0]      sum;
   logic [VALUE_W-1:0]    sat_sum;
   logic                  emit_go;
   logic [START_W-1:0]    prod_start;

   assign clearing = clearing_ff;
   assign emit_go  = !rsp_valid_ff || rsp.ready;

   // one quotient bit per cycle, restoring form
   assign div_trial = {div_rem_ff, div_quo_ff[POS_W-1]};
   assign div_ge    = div_trial >= {1'b0, cfg.bin_width};

   assign mul_a      = (state_ff == S_CHECK) ? div_quo_ff[BIN_W-1:0] : scan_bin_ff[BIN_W-1:0];
   assign prod_in    = PROD_W'(mul_a) * PROD_W'(cfg.bin_width);
   assign prod_start = START_W'(prod_ff + PROD_W'(1));

   assign sum     = {1'b0, mem_q_ff} + SUM_W'(cfg.read_weight);
   assign sat_sum = sum[VALUE_W] ? '1 : sum[VALUE_W-1:0];

   assign rd_addr = (state_ff == S_CHECK) ? {chrom_ff, div_quo_ff[BIN_W-1:0]}
                                          : {chrom_ff, scan_bin_ff[BIN_W-1:0]};
   assign mem_we  = clearing_ff || (state_ff == S_RWAIT);
   assign wr_addr = clearing_ff ? clr_addr_ff : {chrom_ff, div_quo_ff[BIN_W-1:0]};
   assign wr_data = clearing_ff ? '0 : sat_sum;

   always_comb begin
      state_in       = state_ff;
      chrom_in       = chrom_ff;
      div_rem_in     = div_rem_ff;
      div_quo_in     = div_quo_ff;
      div_cnt_in     = div_cnt_ff;
      scan_bin_in    = scan_bin_ff;
      scan_cnt_in    = scan_cnt_ff;
      pend_status_in = pend_status_ff;
      pend_start_in  = pend_start_ff;
      pend_value_in  = pend_value_ff;
      pend_last_in   = pend_last_ff;
      q_pop          = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (q_valid && !clearing_ff) begin
               q_pop       = 1'b1;
               chrom_in    = q_item.chrom;
               scan_bin_in = SCAN_W'(32'(q_item.group) * DUMP_GROUP);
               scan_cnt_in = '0;
               div_rem_in  = '0;
               div_quo_in  = q_item.pos;
               div_cnt_in  = DIV_CNT_W'(POS_W);
               if (q_item.is_dump) begin
                  if (q_item.chrom_ok) begin
                     state_in = S_DRD;
                  end else begin
                     pend_status_in = ST_DUMP;
                     pend_start_in  = '0;
                     pend_value_in  = '0;
                     pend_last_in   = 1'b1;
                     state_in       = S_EMIT;
                  end
               end else if (q_item.status != ST_COUNTED) begin
                  pend_status_in = q_item.status;
                  pend_start_in  = '0;
                  pend_value_in  = '0;
                  pend_last_in   = 1'b1;
                  state_in       = S_EMIT;
               end else begin
                  state_in = S_DIV;
               end
            end
         end
         S_DIV: begin
            div_rem_in = div_ge ? REM_W'(div_trial - {1'b0, cfg.bin_width})
                                : div_trial[REM_W-1:0];
            div_quo_in = {div_quo_ff[POS_W-2:0], div_ge};
            div_cnt_in = div_cnt_ff - 1'b1;
            if (div_cnt_ff == DIV_CNT_W'(1)) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            // store read and bin start product are issued here
            if (div_quo_ff >= POS_W'(BINS_PER_CHROM)) begin
               pend_status_in = ST_RANGE;
               pend_start_in  = '0;
               pend_value_in  = '0;
               pend_last_in   = 1'b1;
               state_in       = S_EMIT;
            end else begin
               state_in = S_RWAIT;
            end
         end
         S_RWAIT: begin
            pend_status_in = ST_COUNTED;
            pend_start_in  = prod_start;
            pend_value_in  = sat_sum;
            pend_last_in   = 1'b1;
            state_in       = S_EMIT;
         end
         S_DRD: begin
            if (scan_cnt_ff == SCAN_CNT_W'(DUMP_GROUP) ||
                32'(scan_bin_ff) >= BINS_PER_CHROM) begin
               pend_status_in = ST_DUMP;
               pend_start_in  = '0;
               pend_value_in  = '0;
               pend_last_in   = 1'b1;
               state_in       = S_EMIT;
            end else begin
               state_in = S_DWAIT;
            end
         end
         S_DWAIT: begin
            scan_bin_in = scan_bin_ff + 1'b1;
            scan_cnt_in = scan_cnt_ff + 1'b1;
            if (mem_q_ff != '0) begin
               pend_status_in = ST_DUMP;
               pend_start_in  = prod_start;
               pend_value_in  = mem_q_ff;
               pend_last_in   = 1'b0;
               state_in       = S_EMIT;
            end else begin
               state_in = S_DRD;
            end
         end
         S_EMIT: begin
            if (emit_go) begin
               state_in = pend_last_ff ? S_IDLE : S_DRD;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      clearing_in = clearing_ff;
      clr_addr_in = clr_addr_ff;
      if (clearing_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == ADDR_W'(STORE_DEPTH - 1)) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_comb begin
      if (state_ff == S_EMIT && emit_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         clearing_ff  <= 1'b1;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clearing_ff  <= clearing_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      chrom_ff       <= chrom_in;
      div_rem_ff     <= div_rem_in;
      div_quo_ff     <= div_quo_in;
      div_cnt_ff     <= div_cnt_in;
      scan_bin_ff    <= scan_bin_in;
      scan_cnt_ff    <= scan_cnt_in;
      prod_ff        <= prod_in;
      pend_status_ff <= pend_status_in;
      pend_start_ff  <= pend_start_in;
      pend_value_ff  <= pend_value_in;
      pend_last_ff   <= pend_last_in;
      if (state_ff == S_EMIT && emit_go) begin
         rsp_status_ff <= pend_status_ff;
         rsp_start_ff  <= pend_start_ff;
         rsp_value_ff  <= pend_value_ff;
         rsp_last_ff   <= pend_last_ff;
      end
   end

   // bin store
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      mem_q_ff <= store[rd_addr];
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.status    = rsp_status_ff;
   assign rsp.bin_start = rsp_start_ff;
   assign rsp.bin_value = rsp_value_ff;
   assign rsp.last      = rsp_last_ff;

   a_no_pop_clearing: assert property (@(posedge clock) disable iff (reset)
      clearing_ff |-> !q_pop)
      else $error("item taken during clearing pass");

   a_store_write_src: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (clearing_ff || state_ff == S_RWAIT))
      else $error("bin store written outside update");

   a_read_to_div: assert property (@(posedge clock) disable iff (reset)
      (q_pop && !q_item.is_dump && q_item.status == ST_COUNTED) |=> state_ff == S_DIV)
      else $error("binnable read did not start division");

   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT && emit_go && pend_last_ff) |=> state_ff == S_IDLE)
      else $error("closing result did not end item");

   a_emit_loads_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT && emit_go) |=> rsp_valid_ff)
      else $error("emitted result not presented");

endmodule

@@ rtl/core/read_position_histogram.sv @@
// Read position histogram top level: register file, front, queue and back.
// Read record: binned by the 33-step bin divider (one quotient bit per cycle) in the
// back; the back finishes one item before it takes the next one from the queue.
// Dump: each bin of the group is read in turn; each nonzero bin gives a result, then the closing marker.
// Reset: synchronous; registers take their defaults, then a clearing pass over all
// 524288 store words zeroes the bin store, one word a cycle, with req_chan.ready low.
module read_position_histogram (
   input  logic                           clock,
   input  logic                           reset,
   rph_req_if.sink                        req_chan,
   rph_rsp_if.source                      rsp_chan,
   input  logic                           csr_wr_en,
   input  logic [rph_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rph_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import rph_pkg::*;

   logic [BS_W-1:0]     bin_width_ff;
   logic [SHIFT_W-1:0]  shift_amount_ff;
   logic [WEIGHT_W-1:0] read_weight_ff;
   logic [SKIP_W-1:0]   skipped_chrom_ff;
   cfg_type             cfg;
   logic                clearing;
   logic                q_full;
   logic                q_push;
   logic                q_valid;
   logic                q_pop;
   work_type            push_item;
   work_type            head_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         bin_width_ff     <= BS_W'(1);
         shift_amount_ff  <= '0;
         read_weight_ff   <= WEIGHT_W'(256);
         skipped_chrom_ff <= SKIP_W'(32);
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_BIN_WIDTH:     bin_width_ff     <= csr_wdata[BS_W-1:0];
            CSR_SHIFT_AMOUNT:  shift_amount_ff  <= csr_wdata[SHIFT_W-1:0];
            CSR_READ_WEIGHT:   read_weight_ff   <= csr_wdata[WEIGHT_W-1:0];
            CSR_SKIPPED_CHROM: skipped_chrom_ff <= csr_wdata[SKIP_W-1:0];
            default: ;
         endcase
      end
   end

   // zero bin size behaves as one
   always_comb begin
      cfg.bin_width     = (bin_width_ff == '0) ? BS_W'(1) : bin_width_ff;
      cfg.shift_amount  = shift_amount_ff;
      cfg.read_weight   = read_weight_ff;
      cfg.skipped_chrom = skipped_chrom_ff;
   end

   rph_front u_front (
      .cfg      (cfg),
      .clearing (clearing),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_item   (push_item),
      .req      (req_chan)
   );

   rph_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .pop       (q_pop),
      .full      (q_full),
      .valid     (q_valid),
      .head_item (head_item)
   );

   rph_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .q_valid  (q_valid),
      .q_item   (head_item),
      .q_pop    (q_pop),
      .clearing (clearing),
      .rsp      (rsp_chan)
   );

endmodule

@@ test/rph_checker.sv @@
// Checker for the read position histogram: mirrors the bins, predicts and compares results.
module rph_checker (
   input  logic                           clock,
   input  logic                           reset,
   rph_req_if                             req_mon,
   rph_rsp_if                             rsp_mon,
   input  logic                           csr_wr_en,
   input  logic [rph_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rph_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                             errors,
   output int                             pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import rph_pkg::*;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [START_W-1:0]  bin_start;
      logic [VALUE_W-1:0]  bin_value;
      logic                last;
   } hist_result_type;

   hist_result_type    expected_results[$];
   hist_result_type    want;
   logic [VALUE_W-1:0] bin_mirror[int unsigned];
   cfg_type            cfg_mirror;
   int                 mismatch_count = 0;

   assign errors = mismatch_count;

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      $display("%0t mismatch: %s", $time, msg);
   endtask

   // Bins never hit are not held in the mirror and read as zero
   function automatic logic [VALUE_W-1:0] mirror_word(input int unsigned addr);
      return bin_mirror.exists(addr) ? bin_mirror[addr] : '0;
   endfunction

   function automatic void queue_result(input logic [STATUS_W-1:0] st,
                                        input longint unsigned start_pos,
                                        input longint unsigned value, input logic fin);
      hist_result_type res;
      res.status    = st;
      res.bin_start = start_pos[START_W-1:0];
      res.bin_value = value[VALUE_W-1:0];
      res.last      = fin;
      expected_results.push_back(res);
   endfunction

   task automatic predict_histogram();
      longint unsigned     chrom, bs, pos, bin, sum, first;
      int unsigned         addr;
      int                  i;
      logic [STATUS_W-1:0] verdict;
      chrom = 64'(req_mon.chrom_index);
      bs    = (cfg_mirror.bin_width == 0) ? 64'd1 : 64'(cfg_mirror.bin_width);
      pos   = 0;
      if (req_mon.req_type == REQ_DUMP) begin
         if (chrom < NUM_CHROMS) begin
            first = 64'(req_mon.bin_group) * DUMP_GROUP;
            for (i = 0; i < DUMP_GROUP; i++) begin
               bin = first + 64'(i);
               if (bin >= BINS_PER_CHROM)
                  break;
               addr = 32'(chrom * BINS_PER_CHROM + bin);
               if (mirror_word(addr) != 0)
                  queue_result(ST_DUMP, bin * bs + 1, 64'(mirror_word(addr)), 1'b0);
            end
         end
         queue_result(ST_DUMP, 0, 0, 1'b1);
      end else begin
         // order of checks: skipped, chromosome range, strand, distance, bin range
         verdict = ST_COUNTED;
         if (chrom == cfg_mirror.skipped_chrom)
            verdict = ST_SKIPPED;
         else if (chrom >= NUM_CHROMS)
            verdict = ST_RANGE;
         else if (req_mon.strand == STRAND_PLUS)
            pos = 64'(req_mon.read_start) + 64'(cfg_mirror.shift_amount);
         else if (req_mon.strand == STRAND_MINUS) begin
            if (64'(req_mon.read_end) > 64'(cfg_mirror.shift_amount))
               pos = 64'(req_mon.read_end) - 64'(cfg_mirror.shift_amount);
            else
               verdict = ST_TOO_CLOSE;
         end else
            verdict = ST_BAD_STRAND;
         if (verdict == ST_COUNTED) begin
            bin = pos / bs;
            if (bin >= BINS_PER_CHROM)
               verdict = ST_RANGE;
            else begin
               addr = 32'(chrom * BINS_PER_CHROM + bin);
               sum  = 64'(mirror_word(addr)) + 64'(cfg_mirror.read_weight);
               if (sum > 64'hFFFF_FFFF)
                  sum = 64'hFFFF_FFFF;
               bin_mirror[addr] = sum[VALUE_W-1:0];
               queue_result(ST_COUNTED, bin * bs + 1, sum, 1'b1);
            end
         end
         if (verdict != ST_COUNTED)
            queue_result(verdict, 0, 0, 1'b1);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cfg_mirror.bin_width     = 1;
         cfg_mirror.shift_amount  = 0;
         cfg_mirror.read_weight   = 256;
         cfg_mirror.skipped_chrom = 32;
         bin_mirror.delete();
         expected_results.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_results.size() == 0)
               report_mismatch($sformatf("unexpected result: status %0d start %0d value %0d",
                                         rsp_mon.status, rsp_mon.bin_start,
                                         rsp_mon.bin_value));
            else begin
               want = expected_results.pop_front();
               if (rsp_mon.status !== want.status)
                  report_mismatch($sformatf("status got %0d want %0d", rsp_mon.status,
                                            want.status));
               if (rsp_mon.bin_start !== want.bin_start)
                  report_mismatch($sformatf("bin_start got %0d want %0d", rsp_mon.bin_start,
                                            want.bin_start));
               if (rsp_mon.bin_value !== want.bin_value)
                  report_mismatch($sformatf("bin_value got %0d want %0d", rsp_mon.bin_value,
                                            want.bin_value));
               if (rsp_mon.last !== want.last)
                  report_mismatch($sformatf("last got %0d want %0d", rsp_mon.last, want.last));
            end
         end
         if (req_mon.valid && req_mon.ready)
            predict_histogram();
         if (csr_wr_en) begin
            case (csr_index)
               CSR_BIN_WIDTH:     cfg_mirror.bin_width     = csr_wdata[BS_W-1:0];
               CSR_SHIFT_AMOUNT:  cfg_mirror.shift_amount  = csr_wdata[SHIFT_W-1:0];
               CSR_READ_WEIGHT:   cfg_mirror.read_weight   = csr_wdata[WEIGHT_W-1:0];
               CSR_SKIPPED_CHROM: cfg_mirror.skipped_chrom = csr_wdata[SKIP_W-1:0];
               default: ;
            endcase
         end
      end
      pending <= expected_results.size();
   end

endmodule

@@ test/testbench.sv @@
// Testbench top for the read position histogram: stimulus, idling, watchdog and verdict.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import rph_pkg::*;

   // the clearing pass after reset is by far the longest quiet stretch
   localparam int IDLE_LIMIT   = 4 * STORE_DEPTH;
   localparam int DRAIN_CYCLES = 60;
   localparam int RANDOM_ITEMS = 56;
   localparam int NUM_PHASES   = 7;

   localparam logic [STRAND_W-1:0] STRAND_UNKNOWN  = 2'd2;
   localparam logic [STRAND_W-1:0] STRAND_RESERVED = 2'd3;

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int                    errors;
   int                    pending;
   bit                    steady;
   int unsigned           hot_chrom[2];
   int unsigned           hot_group[2];
   longint unsigned       cur_bs, cur_shift, cur_skip;

   rph_req_if req_chan();
   rph_rsp_if rsp_chan();

   read_position_histogram dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   rph_checker hist_check (
      .clock     (clock),
      .reset     (reset),
      .req_mon   (req_chan),
      .rsp_mon   (rsp_chan),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .errors    (errors),
      .pending   (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // mostly short, now and then long
   function automatic int idle_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70)
         return $urandom_range(1, 2);
      if (roll < 95)
         return $urandom_range(3, 8);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [COORD_W-1:0] edge_coord();
      case ($urandom_range(0, 3))
         0: return '0;
         1: return '1;
         default: return $urandom;
      endcase
   endfunction

   initial begin : result_backpressure
      int stall_left;
      stall_left    = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_chan.ready <= 1'b1;
            if (!steady && $urandom_range(0, 99) < 20)
               stall_left = idle_gap();
         end
      end
   end

   task automatic send_request(input logic [REQ_TYPE_W-1:0] kind,
                               input logic [CHROM_IDX_W-1:0] chrom,
                               input logic [COORD_W-1:0] start_pos, end_pos,
                               input logic [STRAND_W-1:0] strand,
                               input logic [GROUP_W-1:0] group);
      int gap;
      gap = (steady || $urandom_range(0, 1) == 0) ? 0 : idle_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.req_type    <= kind;
      req_chan.chrom_index <= chrom;
      req_chan.read_start  <= start_pos;
      req_chan.read_end    <= end_pos;
      req_chan.strand      <= strand;
      req_chan.bin_group   <= group;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
   endtask

   task automatic read_record(input int unsigned chrom, input logic [COORD_W-1:0] start_pos,
                              input logic [COORD_W-1:0] end_pos,
                              input logic [STRAND_W-1:0] strand);
      send_request(REQ_READ, CHROM_IDX_W'(chrom), start_pos, end_pos, strand,
                   GROUP_W'($urandom));
   endtask

   task automatic dump_group(input int unsigned chrom, input int unsigned group);
      send_request(REQ_DUMP, CHROM_IDX_W'(chrom), $urandom, $urandom, STRAND_W'($urandom),
                   GROUP_W'(group));
   endtask

   // Places a read inside one of the hot groups, from whichever strand can reach it, else a random plus read
   task automatic aimed_read(input int unsigned chrom);
      longint unsigned bin, pos;
      bit              plus_ok, minus_ok;
      bin = 64'(hot_group[$urandom_range(0, 1)] * DUMP_GROUP +
                $urandom_range(0, DUMP_GROUP - 1));
      pos = bin * cur_bs + 64'($urandom_range(0, 32'(cur_bs - 1)));
      plus_ok  = pos >= cur_shift && pos - cur_shift <= 64'hFFFF_FFFF;
      minus_ok = pos > 0 && pos + cur_shift <= 64'hFFFF_FFFF;
      if (plus_ok && (!minus_ok || $urandom_range(0, 1) == 0))
         read_record(chrom, COORD_W'(pos - cur_shift), $urandom, STRAND_PLUS);
      else if (minus_ok)
         read_record(chrom, $urandom, COORD_W'(pos + cur_shift), STRAND_MINUS);
      else
         read_record(chrom, $urandom, $urandom, STRAND_PLUS);
   endtask

   task automatic random_traffic(input int count);
      int          n, roll;
      int unsigned chrom;
      for (n = 0; n < count; n++) begin
         if (n % 20 == 0)
            steady = ($urandom_range(0, 4) == 0);
         chrom = hot_chrom[$urandom_range(0, 1)];
         if (cur_skip < NUM_CHROMS && $urandom_range(0, 9) == 0)
            chrom = 32'(cur_skip);
         roll = $urandom_range(0, 99);
         if (roll < 60)
            aimed_read(chrom);
         else if (roll < 80)
            dump_group(chrom, ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1023)
                                                          : hot_group[$urandom_range(0, 1)]);
         else
            send_request(($urandom_range(0, 3) == 0) ? REQ_DUMP : REQ_READ,
                         CHROM_IDX_W'($urandom), edge_coord(), edge_coord(),
                         STRAND_W'($urandom), GROUP_W'($urandom));
      end
   endtask

   // Registers change only once every expected result has come back
   task automatic program_registers(input longint unsigned bs, shift, weight, skip);
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_BIN_WIDTH;
      csr_wdata <= CSR_DATA_W'(bs);
      @(negedge clock);
      csr_index <= CSR_SHIFT_AMOUNT;
      csr_wdata <= CSR_DATA_W'(shift);
      @(negedge clock);
      csr_index <= CSR_READ_WEIGHT;
      csr_wdata <= CSR_DATA_W'(weight);
      @(negedge clock);
      csr_index <= CSR_SKIPPED_CHROM;
      csr_wdata <= CSR_DATA_W'(skip);
      @(negedge clock);
      csr_wr_en <= 1'b0;
      cur_bs    = (bs == 0) ? 1 : bs;
      cur_shift = shift;
      cur_skip  = skip;
   endtask

   initial begin : stimulus
      int              ph;
      longint unsigned bs, shift, weight, skip;
      reset                = 1'b1;
      req_chan.valid       = 1'b0;
      req_chan.req_type    = REQ_READ;
      req_chan.chrom_index = '0;
      req_chan.read_start  = '0;
      req_chan.read_end    = '0;
      req_chan.strand      = STRAND_PLUS;
      req_chan.bin_group   = '0;
      csr_wr_en            = 1'b0;
      csr_index            = CSR_BIN_WIDTH;
      csr_wdata            = '0;
      steady               = 1'b0;
      hot_chrom[0] = $urandom_range(0, NUM_CHROMS - 1);
      hot_chrom[1] = $urandom_range(0, NUM_CHROMS - 1);
      hot_group[0] = $urandom_range(0, 3);
      hot_group[1] = $urandom_range(0, 1023);
      cur_bs    = 1;
      cur_shift = 0;
      cur_skip  = 32;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: unit bins, no shift, weight 1.0, nothing skipped
      read_record(0, 0, 32'hFFFF_FFFF, STRAND_PLUS);
      read_record(0, 0, 0, STRAND_PLUS);
      read_record(0, 16383, $urandom, STRAND_PLUS);
      read_record(0, 16384, $urandom, STRAND_PLUS);
      read_record(31, 32'hFFFF_FFFF, $urandom, STRAND_PLUS);
      read_record(0, $urandom, 0, STRAND_MINUS);
      read_record(0, 32'hFFFF_FFFF, 1, STRAND_MINUS);
      read_record(31, $urandom, 32'hFFFF_FFFF, STRAND_MINUS);
      read_record(5, $urandom, $urandom, STRAND_UNKNOWN);
      read_record(31, $urandom, $urandom, STRAND_RESERVED);
      read_record(31, 20, $urandom, STRAND_PLUS);
      dump_group(0, 0);
      dump_group(0, 1023);
      dump_group(31, 1);
      dump_group(7, 512);
      random_traffic(RANDOM_ITEMS);

      for (ph = 1; ph < NUM_PHASES; ph++) begin
         case (ph)
            1: begin
               bs = 0; shift = 100; weight = 65535; skip = 3;
            end
            2: begin
               bs = 1 << 20; shift = 31'h7FFF_FFFF; weight = 0; skip = 31;
            end
            3: begin
               bs = (1 << BS_W) - 1; shift = $urandom_range(0, 32'h7FFF_FFFF);
               weight = $urandom_range(0, 65535); skip = 63;
            end
            4: begin
               bs = $urandom_range(1, 4096); shift = $urandom_range(0, 100000);
               weight = $urandom_range(0, 65535); skip = $urandom_range(0, 32);
            end
            5: begin
               bs = $urandom_range(1, 64); shift = 0; weight = 1; skip = 32;
            end
            default: begin
               bs = 1; shift = $urandom_range(0, 20000); weight = 256;
               skip = $urandom_range(0, NUM_CHROMS - 1);
            end
         endcase
         program_registers(bs, shift, weight, skip);
         if (ph == 1) begin
            // zero bin size acts as one; skipped chromosome wins over a bad strand
            read_record(3, $urandom, $urandom, STRAND_UNKNOWN);
            read_record(3, $urandom, 0, STRAND_MINUS);
            read_record(0, $urandom, 100, STRAND_MINUS);
            read_record(0, $urandom, 101, STRAND_MINUS);
            read_record(0, 32'hFFFF_FFFF, $urandom, STRAND_PLUS);
            read_record(0, 16283, $urandom, STRAND_PLUS);
            dump_group(0, 0);
            dump_group(3, 0);
         end
         random_traffic(RANDOM_ITEMS);
      end

      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // Ends the run when no transfer happens for too long
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("DONE: errors detected");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/core/rph_pkg.sv
rtl/core/rph_req_if.sv
rtl/core/rph_rsp_if.sv
rtl/core/rph_front.sv
rtl/core/rph_queue.sv
rtl/core/rph_back.sv
rtl/core/read_position_histogram.sv
test/rph_checker.sv
test/testbench.sv
